/* rtl/idbnp_pkg.sv */
// ---------------------------------------------------------------------------
// idbnp_pkg: shared types and constants of the ID buffer nearest pick
// Frame limits, field widths, request and register codes, and the search
// window record passed from the window unit to the scan sequencer.
// ---------------------------------------------------------------------------
package idbnp_pkg;

   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int MAX_RADIUS = 15;

   localparam int COORD_W = 8;    // pixel column / row
   localparam int DIM_W   = 9;    // frame size, window end
   localparam int RAD_W   = 4;    // pick radius
   localparam int ID_W    = 32;   // object ID
   localparam int CSR_IDX_W = 1;

   localparam int MEM_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);

   // distance from the cursor inside the window never exceeds twice the radius
   localparam int SPAN_W = $clog2(2 * MAX_RADIUS + 1);
   localparam int DIST_W = 2 * SPAN_W + 1;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_PICK  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

   typedef struct packed {
      logic [COORD_W-1:0] x0;
      logic [DIM_W-1:0]   x1;
      logic [COORD_W-1:0] y0;
      logic [DIM_W-1:0]   y1;
      logic               empty;
   } win_type;

endpackage

/* rtl/idbnp_window.sv */
// ---------------------------------------------------------------------------
// idbnp_window: pick window bounds
// Clamps the window start to zero, then its end to the frame size, and
// flags a window that holds no pixel.
// ---------------------------------------------------------------------------
module idbnp_window (
   input  logic [idbnp_pkg::COORD_W-1:0] cursor_x,
   input  logic [idbnp_pkg::COORD_W-1:0] cursor_y,
   input  logic [idbnp_pkg::RAD_W-1:0]   radius,
   input  logic [idbnp_pkg::DIM_W-1:0]   width,
   input  logic [idbnp_pkg::DIM_W-1:0]   height,
   output idbnp_pkg::win_type            win
);
   import idbnp_pkg::*;

   localparam int LO_W  = COORD_W + 2;
   localparam int END_W = DIM_W + 1;

   logic signed [LO_W-1:0] lo_x, lo_y;
   logic [COORD_W-1:0]     x0, y0;
   logic [END_W-1:0]       side, end_x, end_y;
   logic [DIM_W-1:0]       x1, y1;

   always_comb begin
      side = END_W'({radius, 1'b1});
      lo_x = $signed(LO_W'(cursor_x)) - $signed(LO_W'(radius));
      lo_y = $signed(LO_W'(cursor_y)) - $signed(LO_W'(radius));
      x0   = lo_x[LO_W-1] ? '0 : lo_x[COORD_W-1:0];
      y0   = lo_y[LO_W-1] ? '0 : lo_y[COORD_W-1:0];
      end_x = END_W'(x0) + side;
      end_y = END_W'(y0) + side;
      x1 = (end_x > END_W'(width))  ? width  : end_x[DIM_W-1:0];
      y1 = (end_y > END_W'(height)) ? height : end_y[DIM_W-1:0];

      win.x0    = x0;
      win.y0    = y0;
      win.x1    = x1;
      win.y1    = y1;
      win.empty = (x1 <= DIM_W'(x0)) || (y1 <= DIM_W'(y0));
   end

endmodule

/* rtl/id_buffer_nearest_pick.sv */
// ---------------------------------------------------------------------------
// id_buffer_nearest_pick: object ID frame store with nearest-pixel pick
// Holds a frame of 32-bit IDs (0 is background). A write request stores an
// ID at one pixel; a pick request scans a clamped window around the cursor
// and returns the nearest nonzero ID within the radius, or 0.
// ---------------------------------------------------------------------------
//
//   port group  dir  handshake            carries
//   ----------  ---  -------------------  -----------------------------------
//   req_*       in   req_valid/req_stall  opcode, pos_x, pos_y, radius, ID
//   rsp_*       out  rsp_valid/rsp_stall  picked_id (picks only)
//   csr_*       in   csr_valid/csr_ready  frame_width / frame_height writes
//
// A pick passes through setup, a scan of N pixels, drain and finish, N being the
// number of pixels in the clamped window (at most (2r+1)^2, 961 at r = 15);
// a pick whose clamped window is empty skips to finish. The single read port
// of the ID store delivers one pixel per cycle to the distance compare unit.
// After reset the store is swept to zero, one entry a cycle over all 65536
// entries, with req_stall held high; CSR writes are taken throughout.
// A pick result waits in the output register while rsp_stall is high; the
// next request is taken meanwhile, and a later pick holds at its end.
// ---------------------------------------------------------------------------
module id_buffer_nearest_pick (
   input  logic                            clock,
   input  logic                            reset,

   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_opcode,
   input  logic [idbnp_pkg::COORD_W-1:0]   req_pos_x,
   input  logic [idbnp_pkg::COORD_W-1:0]   req_pos_y,
   input  logic [idbnp_pkg::RAD_W-1:0]     req_pick_radius,
   input  logic [idbnp_pkg::ID_W-1:0]      req_object_id,

   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [idbnp_pkg::ID_W-1:0]      rsp_picked_id,

   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [idbnp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [idbnp_pkg::DIM_W-1:0]     csr_data
);
   import idbnp_pkg::*;

   localparam int PROD_W = COORD_W + DIM_W;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SETUP,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [DIM_W-1:0] frame_width_ff, frame_height_ff;
   logic [DIM_W-1:0] eff_w, eff_h;

   // pick context
   logic [COORD_W-1:0] cx_ff, cy_ff;
   logic [RAD_W-1:0]   rad_ff;
   logic [RAD_W-1:0]   req_rad_sat;
   win_type            win, win_ff;

   // scan position and compare pipeline
   logic [COORD_W-1:0] px_ff, py_ff;
   logic               chk_vld_ff;
   logic [DIST_W-1:0]  d_ff, d_cur;
   logic [DIST_W-1:0]  best_d_ff;
   logic [ID_W-1:0]    best_id_ff;
   logic [DIM_W-1:0]   px_next, py_next;
   logic               row_end, last_px;

   // output register
   logic               rsp_valid_ff;
   logic [ID_W-1:0]    rsp_id_ff;

   // store
   logic [ID_W-1:0]    mem [MEM_DEPTH];
   logic [ID_W-1:0]    rdata_ff;
   logic [ADDR_W-1:0]  clr_addr_ff;
   logic [ADDR_W-1:0]  rd_addr, wr_addr;
   logic [ID_W-1:0]    wr_data;
   logic               wr_en;
   logic [PROD_W-1:0]  rd_prod, wr_prod;

   logic req_accept, req_write_hit;

   // distance unit signals
   logic signed [COORD_W:0] dx_s, dy_s;
   logic [COORD_W:0]        adx, ady;
   logic [SPAN_W-1:0]       adx_t, ady_t;

   // ------------------------------------------------------------------
   // Effective frame size: saturate oversized settings to the store size
   // ------------------------------------------------------------------
   assign eff_w = (frame_width_ff  > DIM_W'(MAX_WIDTH))  ? DIM_W'(MAX_WIDTH)  : frame_width_ff;
   assign eff_h = (frame_height_ff > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : frame_height_ff;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_picked_id = rsp_id_ff;

   assign req_rad_sat = (req_pick_radius > RAD_W'(MAX_RADIUS)) ?
                        RAD_W'(MAX_RADIUS) : req_pick_radius;

   // ------------------------------------------------------------------
   // Window bounds from the latched cursor
   // ------------------------------------------------------------------
   idbnp_window u_window (
      .cursor_x (cx_ff),
      .cursor_y (cy_ff),
      .radius   (rad_ff),
      .width    (eff_w),
      .height   (eff_h),
      .win      (win)
   );

   // ------------------------------------------------------------------
   // Store addressing: row-major with a stride of the effective width
   // ------------------------------------------------------------------
   always_comb begin
      rd_prod = PROD_W'(py_ff) * PROD_W'(eff_w);
      rd_addr = ADDR_W'(rd_prod + PROD_W'(px_ff));
      wr_prod = PROD_W'(req_pos_y) * PROD_W'(eff_w);

      req_write_hit = req_accept && (req_opcode == OP_WRITE) &&
                      (DIM_W'(req_pos_x) < eff_w) && (DIM_W'(req_pos_y) < eff_h);

      if (state_ff == ST_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clr_addr_ff;
         wr_data = '0;
      end else begin
         wr_en   = req_write_hit;
         wr_addr = ADDR_W'(wr_prod + PROD_W'(req_pos_x));
         wr_data = req_object_id;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[rd_addr];
   end

   // ------------------------------------------------------------------
   // Distance unit: squared distance of the pixel being read
   // Inside the window both offsets stay within twice the radius.
   // ------------------------------------------------------------------
   always_comb begin
      dx_s  = $signed({1'b0, px_ff}) - $signed({1'b0, cx_ff});
      dy_s  = $signed({1'b0, py_ff}) - $signed({1'b0, cy_ff});
      adx   = dx_s[COORD_W] ? (COORD_W+1)'(-dx_s) : dx_s;
      ady   = dy_s[COORD_W] ? (COORD_W+1)'(-dy_s) : dy_s;
      adx_t = adx[SPAN_W-1:0];
      ady_t = ady[SPAN_W-1:0];
      d_cur = DIST_W'(adx_t * adx_t) + DIST_W'(ady_t * ady_t);
   end

   // scan stepping: raster order across the window
   always_comb begin
      px_next = DIM_W'(px_ff) + DIM_W'(1);
      py_next = DIM_W'(py_ff) + DIM_W'(1);
      row_end = (px_next == win_ff.x1);
      last_px = row_end && (py_next == win_ff.y1);
   end

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:  if (&clr_addr_ff) state_in = ST_IDLE;
         ST_IDLE:   if (req_accept && (req_opcode == OP_PICK)) state_in = ST_SETUP;
         ST_SETUP:  state_in = win.empty ? ST_FINISH : ST_SCAN;
         ST_SCAN:   if (last_px) state_in = ST_DRAIN;
         ST_DRAIN:  state_in = ST_FINISH;
         ST_FINISH: if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         default:   state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         clr_addr_ff     <= '0;
         frame_width_ff  <= DIM_W'(MAX_WIDTH);
         frame_height_ff <= DIM_W'(MAX_HEIGHT);
         chk_vld_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;

         // CSR writes are taken in any state
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               REG_FRAME_WIDTH:  frame_width_ff  <= csr_data;
               REG_FRAME_HEIGHT: frame_height_ff <= csr_data;
               default: ;
            endcase
         end

         // load a finished pick once the output register is free; drop the
         // result once taken
         if ((state_ff == ST_FINISH) && (!rsp_valid_ff || !rsp_stall)) begin
            rsp_valid_ff <= 1'b1;
            rsp_id_ff    <= best_id_ff;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         // a read is issued in every scan cycle
         chk_vld_ff <= (state_ff == ST_SCAN);

         // compare the pixel read last cycle against the best so far
         if (chk_vld_ff && (rdata_ff != '0) && (d_ff < best_d_ff)) begin
            best_d_ff  <= d_ff;
            best_id_ff <= rdata_ff;
         end

         unique case (state_ff)
            ST_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
            end
            ST_IDLE: begin
               // hold the cursor of a pick
               if (req_accept && (req_opcode == OP_PICK)) begin
                  cx_ff  <= req_pos_x;
                  cy_ff  <= req_pos_y;
                  rad_ff <= req_rad_sat;
               end
            end
            ST_SETUP: begin
               win_ff     <= win;
               px_ff      <= win.x0;
               py_ff      <= win.y0;
               best_d_ff  <= DIST_W'(rad_ff * rad_ff) + DIST_W'(1);
               best_id_ff <= '0;
            end
            ST_SCAN: begin
               // issue one read and its distance; advance in raster order
               d_ff <= d_cur;
               if (row_end) begin
                  px_ff <= win_ff.x0;
                  py_ff <= py_next[COORD_W-1:0];
               end else begin
                  px_ff <= px_next[COORD_W-1:0];
               end
            end
            ST_DRAIN: ;
            ST_FINISH: ;
            default: ;
         endcase
      end
   end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: self-checking bench for id_buffer_nearest_pick
// Writes object IDs into the frame and picks around cursors under a series
// of frame sizes, predicting every picked ID from a mirror of the frame and
// checking each response in order, with random gaps and stalls on both sides.
// ---------------------------------------------------------------------------
module tb;
   import idbnp_pkg::*;

   localparam int IDLE_PCT      = 19;       // share of cycles with a gap or stall
   localparam int SETTLE_CYCLES = 8;        // writes give no response; let the last one land
   localparam int DRAIN_CYCLES  = 1000;     // longer than the slowest pick
   localparam int QUIET_LIMIT   = 200_000;  // a few times the store sweep after reset

   typedef struct packed {
      logic               opcode;
      logic [COORD_W-1:0] pos_x;
      logic [COORD_W-1:0] pos_y;
      logic [RAD_W-1:0]   radius;
      logic [ID_W-1:0]    object_id;
   } pixel_request_type;

   logic                 clock;
   logic                 reset;

   logic                 req_valid;
   logic                 req_stall;
   logic                 req_opcode;
   logic [COORD_W-1:0]   req_pos_x;
   logic [COORD_W-1:0]   req_pos_y;
   logic [RAD_W-1:0]     req_pick_radius;
   logic [ID_W-1:0]      req_object_id;

   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [ID_W-1:0]      rsp_picked_id;

   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DIM_W-1:0]     csr_data;

   // mirror of the block: frame contents and the two size registers
   bit   [ID_W-1:0]      id_frame [MEM_DEPTH];
   logic [DIM_W-1:0]     cfg_width  = 9'd256;
   logic [DIM_W-1:0]     cfg_height = 9'd256;

   pixel_request_type    pending [$];
   logic [ID_W-1:0]      expected_ids [$];
   int                   requests_queued = 0;
   int                   requests_taken  = 0;
   int                   error_count     = 0;
   int                   quiet_cycles    = 0;
   logic                 req_accepted    = 1'b0;
   logic                 steady          = 1'b0;

   id_buffer_nearest_pick dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_pick_radius (req_pick_radius),
      .req_object_id   (req_object_id),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_picked_id   (rsp_picked_id),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Size registers saturate at the frame maximum.
   function automatic int effective_dim(input logic [DIM_W-1:0] value, input int limit);
      return (value > limit) ? limit : int'(value);
   endfunction

   // Nearest nonzero ID within the radius, raster order breaking ties; the
   // window is clamped at the low edge first and then at the frame end.
   function automatic logic [ID_W-1:0] nearest_pick(input int cx, input int cy, input int rad);
      int              w, h, side, x0, y0, x1, y1, best_d, d;
      logic [ID_W-1:0] best_id;
      w = effective_dim(cfg_width, MAX_WIDTH);
      h = effective_dim(cfg_height, MAX_HEIGHT);
      if (rad > MAX_RADIUS) begin
         rad = MAX_RADIUS;
      end
      side    = 2 * rad + 1;
      x0      = (cx - rad < 0) ? 0 : cx - rad;
      y0      = (cy - rad < 0) ? 0 : cy - rad;
      x1      = (x0 + side > w) ? w : x0 + side;
      y1      = (y0 + side > h) ? h : y0 + side;
      best_d  = rad * rad + 1;
      best_id = '0;
      // an empty window runs no iteration and leaves background
      for (int py = y0; py < y1; py++) begin
         for (int px = x0; px < x1; px++) begin
            d = (px - cx) * (px - cx) + (py - cy) * (py - cy);
            if (id_frame[py * w + px] != 0 && d < best_d) begin
               best_d  = d;
               best_id = id_frame[py * w + px];
            end
         end
      end
      return best_id;
   endfunction

   function automatic logic [COORD_W-1:0] to_coord(input int v);
      return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : v[COORD_W-1:0];
   endfunction

   task automatic queue_request(input logic op, input logic [COORD_W-1:0] x,
                                input logic [COORD_W-1:0] y, input logic [RAD_W-1:0] rad,
                                input logic [ID_W-1:0] id);
      pixel_request_type item;
      item.opcode    = op;
      item.pos_x     = x;
      item.pos_y     = y;
      item.radius    = rad;
      item.object_id = id;
      pending.insert(pending.size(), item);
      requests_queued++;
   endtask

   // Mostly clusters: writes scattered round a focus point, mixed with picks near
   // it so that they actually find something. The rest is noise anywhere.
   task automatic queue_random_burst(input int count);
      int               ew, eh, fx, fy, left;
      logic             op;
      logic [RAD_W-1:0] rad;
      logic [ID_W-1:0]  id;
      int               x, y;
      ew   = effective_dim(cfg_width, MAX_WIDTH);
      eh   = effective_dim(cfg_height, MAX_HEIGHT);
      fx   = 0;
      fy   = 0;
      left = 0;
      for (int n = 0; n < count; n++) begin
         id  = $urandom();
         rad = RAD_W'($urandom_range(0, 15));
         if ($urandom_range(99) < 75) begin
            if (left == 0) begin
               fx   = (ew == 0) ? $urandom_range(0, 255) : $urandom_range(0, ew - 1);
               fy   = (eh == 0) ? $urandom_range(0, 255) : $urandom_range(0, eh - 1);
               left = $urandom_range(4, 12);
            end
            left--;
            if ($urandom_range(99) < 55) begin
               op = OP_WRITE;
               x  = fx + int'($urandom_range(0, 8)) - 4;
               y  = fy + int'($urandom_range(0, 8)) - 4;
               if ($urandom_range(9) == 0) begin
                  id = '0;   // erase back to background
               end
            end else begin
               op  = OP_PICK;
               x   = fx + int'($urandom_range(0, 6)) - 3;
               y   = fy + int'($urandom_range(0, 6)) - 3;
               // keep most scans short; only a few run the full radius
               rad = ($urandom_range(99) < 85) ? RAD_W'($urandom_range(0, 6)) :
                                                 RAD_W'($urandom_range(7, 15));
            end
         end else begin
            op = $urandom_range(0, 1) ? OP_PICK : OP_WRITE;
            x  = $urandom_range(0, 255);
            y  = $urandom_range(0, 255);
         end
         queue_request(op, to_coord(x), to_coord(y), rad, id);
      end
   endtask

   task automatic write_frame_reg(input logic [CSR_IDX_W-1:0] reg_index,
                                  input logic [DIM_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= reg_index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      if (reg_index == REG_FRAME_WIDTH) begin
         cfg_width = value;
      end else begin
         cfg_height = value;
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Wait until every request is taken and every pick has answered, then
   // give the last write time to land.
   task automatic wait_idle(input int extra);
      while (requests_taken != requests_queued || expected_ids.size() != 0) begin
         @(negedge clock);
      end
      repeat (extra) @(negedge clock);
   endtask

   task automatic start_phase(input logic [DIM_W-1:0] width, input logic [DIM_W-1:0] height,
                              input logic no_idle);
      wait_idle(SETTLE_CYCLES);
      write_frame_reg(REG_FRAME_WIDTH, width);
      write_frame_reg(REG_FRAME_HEIGHT, height);
      // queue on the rising edge so the driver never races the fill
      @(posedge clock);
      steady = no_idle;
   endtask

   // Stimulus: directed checks on the full frame, then random bursts under a
   // run of frame sizes, the extremes among them.
   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_opcode      = OP_WRITE;
      req_pos_x       = '0;
      req_pos_y       = '0;
      req_pick_radius = '0;
      req_object_id   = '0;
      rsp_stall       = 1'b0;
      csr_valid       = 1'b0;
      csr_index       = REG_FRAME_WIDTH;
      csr_data        = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      start_phase(9'd256, 9'd256, 1'b0);
      // corners, all-ones and single-bit IDs
      queue_request(OP_WRITE, 8'd0,   8'd0,   4'd0,  32'hFFFF_FFFF);
      queue_request(OP_WRITE, 8'd255, 8'd255, 4'd15, 32'h0000_0001);
      queue_request(OP_WRITE, 8'd255, 8'd0,   4'd0,  32'hA5A5_5A5A);
      queue_request(OP_WRITE, 8'd0,   8'd255, 4'd0,  32'h5A5A_A5A5);
      queue_request(OP_PICK,  8'd0,   8'd0,   4'd0,  32'h0);
      queue_request(OP_PICK,  8'd255, 8'd255, 4'd15, 32'h0);
      queue_request(OP_PICK,  8'd250, 8'd5,   4'd15, 32'h0);
      // nothing within reach: background
      queue_request(OP_PICK,  8'd128, 8'd128, 4'd15, 32'hFFFF_FFFF);
      // equal distances: the earlier row wins, then the leftmost pixel
      queue_request(OP_WRITE, 8'd100, 8'd99,  4'd0,  32'h0000_0011);
      queue_request(OP_WRITE, 8'd99,  8'd100, 4'd0,  32'h0000_0022);
      queue_request(OP_WRITE, 8'd101, 8'd100, 4'd0,  32'h0000_0033);
      queue_request(OP_PICK,  8'd100, 8'd100, 4'd1,  32'h0);
      queue_request(OP_PICK,  8'd100, 8'd101, 4'd2,  32'h0);
      // distance exactly radius squared is in, one radius less is out
      queue_request(OP_WRITE, 8'd50,  8'd53,  4'd0,  32'h0000_0044);
      queue_request(OP_PICK,  8'd50,  8'd50,  4'd3,  32'h0);
      queue_request(OP_PICK,  8'd50,  8'd50,  4'd2,  32'h0);
      // erase with a zero ID
      queue_request(OP_WRITE, 8'd50,  8'd53,  4'd0,  32'h0);
      queue_request(OP_PICK,  8'd50,  8'd50,  4'd3,  32'h0);
      // window clipped at the frame origin
      queue_request(OP_PICK,  8'd3,   8'd2,   4'd15, 32'h0);
      queue_random_burst(70);

      // small frame: write outside is dropped, cursor outside still reaches in
      start_phase(9'd10, 9'd7, 1'b0);
      queue_request(OP_WRITE, 8'd9,   8'd6,   4'd0,  32'h0BAD_CAFE);
      queue_request(OP_WRITE, 8'd10,  8'd0,   4'd0,  32'h0000_0077);
      queue_request(OP_PICK,  8'd12,  8'd6,   4'd3,  32'h0);
      queue_request(OP_PICK,  8'd200, 8'd200, 4'd15, 32'h0);
      queue_random_burst(70);

      // empty frames: writes dropped, picks give background
      start_phase(9'd0, 9'd256, 1'b0);
      queue_random_burst(40);
      start_phase(9'd256, 9'd0, 1'b0);
      queue_random_burst(40);

      // oversized registers saturate; run this one without gaps or stalls
      start_phase(9'd511, 9'd511, 1'b1);
      queue_random_burst(70);

      start_phase(9'd1, 9'd1, 1'b0);
      queue_random_burst(50);
      start_phase(9'd1, 9'd256, 1'b0);
      queue_random_burst(50);
      start_phase(9'd256, 9'd1, 1'b0);
      queue_random_burst(50);

      repeat (3) begin
         start_phase(DIM_W'($urandom_range(1, 300)), DIM_W'($urandom_range(1, 300)), 1'b0);
         queue_random_burst(55);
      end

      wait_idle(DRAIN_CYCLES);
      if (error_count == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

   // Driver: present the next request at the falling edge once the current
   // one is taken; hold it otherwise. Drop valid at random to leave gaps.
   always @(negedge clock) begin : drive
      pixel_request_type next_req;
      rsp_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
      if (!reset && (!req_valid || req_accepted)) begin
         if (pending.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
            next_req = pending.pop_front();
            req_valid       <= 1'b1;
            req_opcode      <= next_req.opcode;
            req_pos_x       <= next_req.pos_x;
            req_pos_y       <= next_req.pos_y;
            req_pick_radius <= next_req.radius;
            req_object_id   <= next_req.object_id;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: check responses against the oldest expectation, then fold each
   // accepted request into the frame mirror. A pick always answers after the
   // cycle in which it is taken, so checking first is safe.
   always @(posedge clock) begin : observe
      int              w, h;
      logic [ID_W-1:0] want;
      logic            rsp_fire, csr_fire;
      req_accepted = req_valid && !req_stall;
      rsp_fire     = rsp_valid && !rsp_stall;
      csr_fire     = csr_valid && csr_ready;

      if (rsp_fire) begin
         if (expected_ids.size() == 0) begin
            $error("picked_id: expected none, actual %h", rsp_picked_id);
            error_count++;
         end else begin
            want = expected_ids.pop_front();
            if (rsp_picked_id !== want) begin
               $error("picked_id: expected %h, actual %h", want, rsp_picked_id);
               error_count++;
            end
         end
      end

      if (req_accepted) begin
         requests_taken++;
         if (req_opcode == OP_WRITE) begin
            w = effective_dim(cfg_width, MAX_WIDTH);
            h = effective_dim(cfg_height, MAX_HEIGHT);
            // writes outside the frame, and all writes to an empty one, are dropped
            if (req_pos_x < w && req_pos_y < h) begin
               id_frame[req_pos_y * w + req_pos_x] = req_object_id;
            end
         end else begin
            expected_ids.insert(expected_ids.size(),
                                nearest_pick(req_pos_x, req_pos_y, req_pick_radius));
         end
      end

      // watchdog: the store sweep after reset is the longest quiet spell
      if (req_accepted || rsp_fire || csr_fire) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

endmodule
